/* hdl/rbcm_pkg.sv */
// Shared types, widths and register codes for the rotated blit coordinate mapper.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package rbcm_pkg;

    localparam int COORD_BITS     = 12;
    localparam int TRIG_FRAC_BITS = 14;

    // Register widths
    localparam int TRIG_W   = TRIG_FRAC_BITS + 2;
    localparam int CENTER_W = COORD_BITS + 1;
    localparam int SIZE_W   = COORD_BITS + 1;
    localparam int FLIP_W   = 2;
    localparam int CFG_DATA_W = (TRIG_W > SIZE_W) ? TRIG_W : SIZE_W;
    localparam int CFG_IDX_W  = 3;

    // Datapath widths
    localparam int RX_W   = ((COORD_BITS + 1 > CENTER_W) ? COORD_BITS + 1 : CENTER_W) + 1;
    localparam int PROD_W = RX_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int ROT_W  = SUM_W - TRIG_FRAC_BITS;
    localparam int POS_W  = ((ROT_W > SIZE_W) ? ROT_W : SIZE_W) + 2;

    localparam int NSTAGE = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_W    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP     = 3'd6;

    localparam logic [TRIG_W-1:0] COS_RESET = TRIG_W'(1) << TRIG_FRAC_BITS;

    localparam int FLIP_H_BIT = 0;
    localparam int FLIP_V_BIT = 1;

    typedef struct packed {
        logic signed [TRIG_W-1:0]   cos_q;
        logic signed [TRIG_W-1:0]   sin_q;
        logic signed [CENTER_W-1:0] center_x;
        logic signed [CENTER_W-1:0] center_y;
        logic        [SIZE_W-1:0]   src_width;
        logic        [SIZE_W-1:0]   src_height;
        logic        [FLIP_W-1:0]   flip_mode;
    } t_cfg;

    // Per-stage load enables from the pipeline control
    typedef struct packed {
        logic [NSTAGE-1:0] adv;
    } t_pipe_ctl;

endpackage

/* hdl/rotated_blit_coordinate_mapper_core.sv */
// Top level of the rotated blit coordinate mapper: pipeline control and stage wiring.
// Depends on rbcm_pkg, rbcm_regs, rbcm_offset, rbcm_rotate, rbcm_place.
`timescale 1ns / 1ps

// Maps each destination pixel to the source pixel that rotates onto it (nearest
// neighbor, inverse rotation by the programmed Q2.14 cosine and sine about the
// programmed center, recentered on the source, optional mirroring). The block
// takes one item per clock while the input is not stalled and returns its result
// through a five-stage pipeline: offset, multiply, sum, scale/recenter, mirror/bounds.
// Each stage holds its own valid bit, so bubbles are squeezed out under output
// stall and the input stalls only when every stage is full. Out-of-bounds
// results carry zero source coordinates. Write registers only while the
// pipeline is empty.
module rotated_blit_coordinate_mapper_core
    import rbcm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_dst_col,
    input  logic [COORD_BITS-1:0] i_dst_row,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_in_bounds,
    output logic [COORD_BITS-1:0] o_src_col,
    output logic [COORD_BITS-1:0] o_src_row,
    output logic [COORD_BITS-1:0] o_out_dst_col,
    output logic [COORD_BITS-1:0] o_out_dst_row
);

    t_cfg      w_cfg;
    t_pipe_ctl w_ctl;

    logic [NSTAGE-1:0]     r_vld;
    logic [NSTAGE:0]       w_rdy;
    logic [NSTAGE-1:0]     w_up_vld;
    logic [COORD_BITS-1:0] r_col [NSTAGE];
    logic [COORD_BITS-1:0] r_row [NSTAGE];

    logic signed [RX_W-1:0]  w_rx, w_ry;
    logic signed [POS_W-1:0] w_x, w_y;

    // A stage may load when it is empty or its content moves on
    always_comb begin
        w_rdy[NSTAGE] = !i_out_stall;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_up_vld = {r_vld[NSTAGE-2:0], i_in_valid};
        w_ctl.adv = w_up_vld & w_rdy[NSTAGE-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTAGE; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_up_vld[k];
                end
            end
        end
    end

    // Carry the destination coordinate alongside the datapath
    always_ff @(posedge i_clk) begin
        if (w_ctl.adv[0]) begin
            r_col[0] <= i_dst_col;
            r_row[0] <= i_dst_row;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (w_ctl.adv[k]) begin
                r_col[k] <= r_col[k-1];
                r_row[k] <= r_row[k-1];
            end
        end
    end

    rbcm_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    rbcm_offset u_offset (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_cfg (w_cfg),
        .i_col (i_dst_col),
        .i_row (i_dst_row),
        .o_rx  (w_rx),
        .o_ry  (w_ry)
    );

    rbcm_rotate u_rotate (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_cfg (w_cfg),
        .i_rx  (w_rx),
        .i_ry  (w_ry),
        .o_x   (w_x),
        .o_y   (w_y)
    );

    rbcm_place u_place (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_cfg       (w_cfg),
        .i_x         (w_x),
        .i_y         (w_y),
        .o_in_bounds (o_in_bounds),
        .o_src_col   (o_src_col),
        .o_src_row   (o_src_row)
    );

    assign o_in_stall    = !w_rdy[0];
    assign o_out_valid   = r_vld[NSTAGE-1];
    assign o_out_dst_col = r_col[NSTAGE-1];
    assign o_out_dst_row = r_row[NSTAGE-1];

endmodule

/* hdl/rbcm_regs.sv */
// Configuration register file of the coordinate mapper.
// Depends on rbcm_pkg.
`timescale 1ns / 1ps

module rbcm_regs
    import rbcm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_q      <= COS_RESET;
            r_cfg.sin_q      <= '0;
            r_cfg.center_x   <= '0;
            r_cfg.center_y   <= '0;
            r_cfg.src_width  <= '0;
            r_cfg.src_height <= '0;
            r_cfg.flip_mode  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COS:      r_cfg.cos_q      <= i_cfg_data[TRIG_W-1:0];
                REG_SIN:      r_cfg.sin_q      <= i_cfg_data[TRIG_W-1:0];
                REG_CENTER_X: r_cfg.center_x   <= i_cfg_data[CENTER_W-1:0];
                REG_CENTER_Y: r_cfg.center_y   <= i_cfg_data[CENTER_W-1:0];
                REG_SRC_W:    r_cfg.src_width  <= i_cfg_data[SIZE_W-1:0];
                REG_SRC_H:    r_cfg.src_height <= i_cfg_data[SIZE_W-1:0];
                REG_FLIP:     r_cfg.flip_mode  <= i_cfg_data[FLIP_W-1:0];
                default: ;    // drop writes past the last register
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/rbcm_offset.sv */
// Stage 0: offset of the destination pixel from the rotation center.
// Depends on rbcm_pkg.
`timescale 1ns / 1ps

module rbcm_offset
    import rbcm_pkg::*;
(
    input  logic                   i_clk,
    input  t_pipe_ctl              i_ctl,
    input  t_cfg                   i_cfg,
    input  logic [COORD_BITS-1:0]  i_col,
    input  logic [COORD_BITS-1:0]  i_row,
    output logic signed [RX_W-1:0] o_rx,
    output logic signed [RX_W-1:0] o_ry
);

    logic signed [RX_W-1:0] r_rx;
    logic signed [RX_W-1:0] r_ry;
    logic signed [RX_W-1:0] n_rx;
    logic signed [RX_W-1:0] n_ry;

    always_comb begin
        n_rx = RX_W'(signed'({1'b0, i_col})) - RX_W'(i_cfg.center_x);
        n_ry = RX_W'(signed'({1'b0, i_row})) - RX_W'(i_cfg.center_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r_rx <= n_rx;
            r_ry <= n_ry;
        end
    end

    assign o_rx = r_rx;
    assign o_ry = r_ry;

endmodule

/* hdl/rbcm_rotate.sv */
// Stages 1-3: inverse rotation products, sums, truncation and recentering.
// Depends on rbcm_pkg.
`timescale 1ns / 1ps

module rbcm_rotate
    import rbcm_pkg::*;
(
    input  logic                    i_clk,
    input  t_pipe_ctl               i_ctl,
    input  t_cfg                    i_cfg,
    input  logic signed [RX_W-1:0]  i_rx,
    input  logic signed [RX_W-1:0]  i_ry,
    output logic signed [POS_W-1:0] o_x,
    output logic signed [POS_W-1:0] o_y
);

    localparam logic signed [SUM_W-1:0] FRAC_MASK = SUM_W'((1 << TRIG_FRAC_BITS) - 1);

    logic signed [PROD_W-1:0] r_xc, r_ys, r_yc, r_xs;
    logic signed [SUM_W-1:0]  r_sx, r_sy;
    logic signed [POS_W-1:0]  r_x, r_y;

    logic signed [SUM_W-1:0]  n_bx, n_by;
    logic signed [ROT_W-1:0]  n_tx, n_ty;
    logic signed [POS_W-1:0]  n_hw, n_hh;

    // Stage 1: four products
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[1]) begin
            r_xc <= PROD_W'(i_rx) * PROD_W'(i_cfg.cos_q);
            r_ys <= PROD_W'(i_ry) * PROD_W'(i_cfg.sin_q);
            r_yc <= PROD_W'(i_ry) * PROD_W'(i_cfg.cos_q);
            r_xs <= PROD_W'(i_rx) * PROD_W'(i_cfg.sin_q);
        end
    end

    // Stage 2: rotated sums
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[2]) begin
            r_sx <= SUM_W'(r_xc) + SUM_W'(r_ys);
            r_sy <= SUM_W'(r_yc) - SUM_W'(r_xs);
        end
    end

    // Stage 3: scale down toward zero, then add half the source size
    always_comb begin
        n_bx = r_sx + (r_sx[SUM_W-1] ? FRAC_MASK : '0);
        n_by = r_sy + (r_sy[SUM_W-1] ? FRAC_MASK : '0);
        n_tx = ROT_W'(n_bx >>> TRIG_FRAC_BITS);
        n_ty = ROT_W'(n_by >>> TRIG_FRAC_BITS);
        n_hw = POS_W'(signed'({1'b0, i_cfg.src_width[SIZE_W-1:1]}));
        n_hh = POS_W'(signed'({1'b0, i_cfg.src_height[SIZE_W-1:1]}));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[3]) begin
            r_x <= POS_W'(n_tx) + n_hw;
            r_y <= POS_W'(n_ty) + n_hh;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

/* hdl/rbcm_place.sv */
// Stage 4: mirroring, bounds check and the result register.
// Depends on rbcm_pkg.
`timescale 1ns / 1ps

module rbcm_place
    import rbcm_pkg::*;
(
    input  logic                    i_clk,
    input  t_pipe_ctl               i_ctl,
    input  t_cfg                    i_cfg,
    input  logic signed [POS_W-1:0] i_x,
    input  logic signed [POS_W-1:0] i_y,
    output logic                    o_in_bounds,
    output logic [COORD_BITS-1:0]   o_src_col,
    output logic [COORD_BITS-1:0]   o_src_row
);

    localparam logic signed [POS_W-1:0] ONE = POS_W'(1);

    logic signed [POS_W-1:0] n_w, n_h, n_fx, n_fy;
    logic                    n_in;
    logic                    r_in;
    logic [COORD_BITS-1:0]   r_col, r_row;

    always_comb begin
        n_w  = POS_W'(signed'({1'b0, i_cfg.src_width}));
        n_h  = POS_W'(signed'({1'b0, i_cfg.src_height}));
        n_fx = i_cfg.flip_mode[FLIP_H_BIT] ? (n_w - ONE - i_x) : i_x;
        n_fy = i_cfg.flip_mode[FLIP_V_BIT] ? (n_h - ONE - i_y) : i_y;
        n_in = !n_fx[POS_W-1] && (n_fx < n_w) && !n_fy[POS_W-1] && (n_fy < n_h);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[4]) begin
            r_in  <= n_in;
            r_col <= n_in ? n_fx[COORD_BITS-1:0] : '0;
            r_row <= n_in ? n_fy[COORD_BITS-1:0] : '0;
        end
    end

    assign o_in_bounds = r_in;
    assign o_src_col   = r_col;
    assign o_src_row   = r_row;

endmodule

/* hdl/rbcm_checker.sv */
// Port-level checks for the coordinate mapper, bound to the top level.
// Depends on rbcm_pkg and rotated_blit_coordinate_mapper_core.
`timescale 1ns / 1ps

module rbcm_checker
    import rbcm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic                  o_in_bounds,
    input logic [COORD_BITS-1:0] o_src_col,
    input logic [COORD_BITS-1:0] o_src_row,
    input logic [COORD_BITS-1:0] o_out_dst_col,
    input logic [COORD_BITS-1:0] o_out_dst_row
);

    // A blocked result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A blocked result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_dst_col) && $stable(o_out_dst_row)
            && $stable(o_src_col) && $stable(o_src_row) && $stable(o_in_bounds))
        else $error("stalled result changed");

    // Input backs up only when the output is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    // Out-of-bounds results carry zero source coordinates
    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_bounds |-> o_src_col == '0 && o_src_row == '0)
        else $error("out-of-bounds result with nonzero coordinates");

endmodule

bind rotated_blit_coordinate_mapper_core rbcm_checker u_rbcm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_in_bounds   (o_in_bounds),
    .o_src_col     (o_src_col),
    .o_src_row     (o_src_row),
    .o_out_dst_col (o_out_dst_col),
    .o_out_dst_row (o_out_dst_row)
);
